@@ design/gpww_pkg.sv @@
// Package with shared types, constants and command/status bundles of the word wrapper.
`timescale 1ns / 1ps
package gpww_pkg;

  localparam int unsigned MaxWord = 40;
  localparam int unsigned LenW    = $clog2(MaxWord + 1);
  localparam int unsigned PtrW    = $clog2(MaxWord);
  localparam int unsigned ColW    = 8;
  localparam int unsigned SumW    = ColW + 2;

  localparam logic [7:0] CharSp     = 8'h20;
  localparam logic [7:0] CharNl     = 8'h0a;
  localparam logic [7:0] WidthReset = 8'd40;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       word_truncated;
  } out_item_t;

  typedef enum logic [1:0] {
    EmitNl   = 2'd0,
    EmitSp   = 2'd1,
    EmitWord = 2'd2
  } emit_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      store_byte;
    logic      set_lhb;
    logic      clr_lhb;
    logic      ovf_clr;
    logic      col_len;
    logic      col_add;
    logic      col_clr;
    logic      bp_set;
    logic      bp_clr;
    logic      ptr_clr;
    logic      ptr_adv;
    logic      word_done;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic is_nl;
    logic is_sp;
    logic len_zero;
    logic col_zero;
    logic bp;
    logic lhb;
    logic fits;
    logic word_last;
    logic slot_free;
  } dp_stat_t;

endpackage

@@ design/greedy_paragraph_word_wrap.sv @@
// Top level of the greedy paragraph word wrapper: controller plus datapath.
// Items: a word byte item is taken while idle and only buffered, with no result; a
//   separator or end item is taken while idle and its results, if any, follow.
// Throughput: the emit loop gives one result a cycle while the output slot is free
//   (the word buffer read port supplies one byte a cycle); items wait during a run.
// Reset: rst_ni (async, low) clears the line state and sets line_width to 40;
//   the word buffer itself is not cleared, only entries already written are read.
`timescale 1ns / 1ps
module greedy_paragraph_word_wrap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gpww_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gpww_pkg::out_item_t out_item_o
);
  import gpww_pkg::*;

  // Command and status bundles between controller and datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: takes an item only when idle, then walks blank line,
  // separator, word bytes and closing newline one result per cycle while the slot is free.
  gpww_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: word buffer, column tracking, line_width register and the
  // output register that decouples the result side from the controller.
  gpww_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ design/gpww_datapath.sv @@
// Datapath: word buffer memory, line state registers and output register.
`timescale 1ns / 1ps
module gpww_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  gpww_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output gpww_pkg::out_item_t out_item_o,
  input  gpww_pkg::dp_cmd_t   cmd_i,
  output gpww_pkg::dp_stat_t  stat_o
);
  import gpww_pkg::*;

  logic [7:0]      mem [MaxWord];
  logic [7:0]      rd_q;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [ColW-1:0] col_q, col_d;
  logic            lhb_q, lhb_d;
  logic            bp_q, bp_d;
  logic [7:0]      width_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic [SumW-1:0] sum;
  logic            room;
  logic [7:0]      emit_byte;

  assign room = (len_q < LenW'(MaxWord));
  assign sum  = {2'b00, col_q} + SumW'(len_q) + SumW'(1);

  assign stat_o.is_end    = in_item_i.command;
  assign stat_o.is_nl     = (in_item_i.in_byte == CharNl);
  assign stat_o.is_sp     = (in_item_i.in_byte == CharSp);
  assign stat_o.len_zero  = (len_q == '0);
  assign stat_o.col_zero  = (col_q == '0);
  assign stat_o.bp        = bp_q;
  assign stat_o.lhb       = lhb_q;
  assign stat_o.fits      = (sum <= {2'b00, width_q});
  assign stat_o.word_last = (LenW'(ptr_q) == (len_q - LenW'(1)));
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;

  // Read port: keep the byte at the pointer registered.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_adv) begin
      ptr_d = ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[ptr_d];
    if (cmd_i.store_byte && room) begin
      mem[len_q[PtrW-1:0]] <= in_item_i.in_byte;
    end
  end

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (cmd_i.store_byte) begin
      if (room) begin
        len_d = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.ovf_clr) begin
      ovf_d = 1'b0;
    end
    if (cmd_i.word_done) begin
      len_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_comb begin
    col_d = col_q;
    if (cmd_i.col_len) begin
      col_d = ColW'(len_q);
    end else if (cmd_i.col_add) begin
      col_d = sum[ColW-1:0];
    end else if (cmd_i.col_clr) begin
      col_d = '0;
    end
    lhb_d = lhb_q;
    if (cmd_i.set_lhb) begin
      lhb_d = 1'b1;
    end else if (cmd_i.clr_lhb) begin
      lhb_d = 1'b0;
    end
    bp_d = bp_q;
    if (cmd_i.bp_set) begin
      bp_d = 1'b1;
    end else if (cmd_i.bp_clr) begin
      bp_d = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.emit_sel)
      EmitSp:   emit_byte = CharSp;
      EmitWord: emit_byte = rd_q;
      default:  emit_byte = CharNl;
    endcase
    out_d.out_byte       = emit_byte;
    out_d.last_of_run    = cmd_i.emit_last;
    out_d.word_truncated = (cmd_i.emit_sel == EmitWord) && ovf_q;
    out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      col_q       <= '0;
      lhb_q       <= 1'b0;
      bp_q        <= 1'b0;
      width_q     <= WidthReset;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      col_q       <= col_d;
      lhb_q       <= lhb_d;
      bp_q        <= bp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ design/gpww_ctrl.sv @@
// Controller: sequences the results of one item and drives datapath commands.
`timescale 1ns / 1ps
module gpww_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gpww_pkg::dp_stat_t stat_i,
  output gpww_pkg::dp_cmd_t  cmd_o
);
  import gpww_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SBlank = 3'd1;
  localparam logic [2:0] SSep   = 3'd2;
  localparam logic [2:0] SWord  = 3'd3;
  localparam logic [2:0] SFinal = 3'd4;
  localparam logic [2:0] SPara  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       is_end_q, is_end_d;
  logic       do_flush;

  always_comb begin
    state_d  = state_q;
    is_end_d = is_end_q;
    cmd_o    = '0;
    cmd_o.emit_sel = EmitNl;
    do_flush = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (stat_i.is_end) begin
            cmd_o.clr_lhb = 1'b1;
            if (stat_i.len_zero) begin
              cmd_o.ovf_clr = 1'b1;
              cmd_o.bp_clr  = 1'b1;
              if (!stat_i.col_zero) begin
                state_d = SFinal;
              end
            end else begin
              do_flush = 1'b1;
            end
          end else if (stat_i.is_nl) begin
            cmd_o.clr_lhb = 1'b1;
            if (!stat_i.lhb) begin
              if (!stat_i.col_zero) begin
                state_d = SPara;
              end
            end else begin
              do_flush = 1'b1;
            end
          end else if (stat_i.is_sp) begin
            cmd_o.set_lhb = 1'b1;
            do_flush = 1'b1;
          end else begin
            cmd_o.store_byte = 1'b1;
            cmd_o.set_lhb    = 1'b1;
          end
          // Start a word flush: empty words only drop the overflow mark.
          if (do_flush) begin
            if (stat_i.len_zero) begin
              cmd_o.ovf_clr = 1'b1;
            end else begin
              cmd_o.ptr_clr = 1'b1;
              is_end_d      = stat_i.is_end;
              if (stat_i.bp) begin
                state_d = SBlank;
              end else if (!stat_i.col_zero) begin
                state_d = SSep;
              end else begin
                cmd_o.col_len = 1'b1;
                state_d       = SWord;
              end
            end
          end
        end
      end
      SBlank: begin
        if (stat_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.bp_clr  = 1'b1;
          cmd_o.col_len = 1'b1;
          state_d       = SWord;
        end
      end
      SSep: begin
        if (stat_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = stat_i.fits ? EmitSp : EmitNl;
          cmd_o.col_add  = stat_i.fits;
          cmd_o.col_len  = !stat_i.fits;
          state_d        = SWord;
        end
      end
      SWord: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EmitWord;
          cmd_o.emit_last = stat_i.word_last && !is_end_q;
          if (stat_i.word_last) begin
            cmd_o.word_done = 1'b1;
            state_d = is_end_q ? SFinal : SIdle;
          end else begin
            cmd_o.ptr_adv = 1'b1;
          end
        end
      end
      SFinal: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.col_clr   = 1'b1;
          cmd_o.bp_clr    = 1'b1;
          state_d         = SIdle;
        end
      end
      SPara: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.col_clr   = 1'b1;
          cmd_o.bp_set    = 1'b1;
          state_d         = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      is_end_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_end_q <= is_end_d;
    end
  end

endmodule

@@ design/gpww_checker.sv @@
// Port-level checker for the word wrapper and its bind to the top level.
`timescale 1ns / 1ps
module gpww_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input gpww_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gpww_pkg::out_item_t out_item_o
);
  import gpww_pkg::*;

  // Hold a stalled item.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A plain word byte is only buffered: the block is free again next cycle.
  a_word_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_item_i.command &&
    in_item_i.in_byte != CharSp && in_item_i.in_byte != CharNl |=> !in_stall_o)
    else $error("word byte kept the block busy");

  // Truncated results are word bytes, never separators.
  a_trunc_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.word_truncated |->
    out_item_o.out_byte != CharSp && out_item_o.out_byte != CharNl)
    else $error("separator flagged as truncated");

  // More results of the run are still to come, so no new item may enter.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> in_stall_o)
    else $error("item taken in the middle of a run");

endmodule

bind greedy_paragraph_word_wrap gpww_checker u_gpww_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
